@@ rtl/mrm_pkg.sv @@
// ----------------------------------------------------------------------------
// mrm_pkg
// Shared types and codes for the memory region map allocator.
// ----------------------------------------------------------------------------
package mrm_pkg;

  // Request opcodes
  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_CLAIM = 2'd1,
    OP_ALLOC = 2'd2,
    OP_QUERY = 2'd3
  } op_e;

  // Result status codes
  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_NOFIT     = 3'd1;
  localparam logic [2:0] STS_FULL      = 3'd2;
  localparam logic [2:0] STS_OVERLAP   = 3'd3;
  localparam logic [2:0] STS_OUTSIDE   = 3'd4;
  localparam logic [2:0] STS_ZERO_UNIT = 3'd5;

  // Region classes and uses with special meaning
  localparam logic [2:0] CLASS_UNUSED = 3'd0;
  localparam logic [2:0] CLASS_RAM    = 3'd2;
  localparam logic [3:0] USE_AVAIL    = 4'd0;
  localparam logic [3:0] USE_DEV      = 4'd9;
  localparam logic [3:0] USE_DEVPAGES = 4'd10;

  // Saturation value of the unit count
  localparam logic [48:0] CNT_MAX = {49{1'b1}};

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CLAIM_BEGIN,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_CLIP,
    ST_FIT,
    ST_PICK,
    ST_DIV,
    ST_ADD_WR,
    ST_CLAIM_CHK,
    ST_WR_LO,
    ST_WR_HI,
    ST_WR_CUR,
    ST_MG_RDI,
    ST_MG_LDI,
    ST_MG_RDJ,
    ST_MG_EVJ
  } state_e;

endpackage

@@ rtl/memory_region_map_allocator_top.sv @@
// ----------------------------------------------------------------------------
// memory_region_map_allocator_top
// Region table with add, claim, allocate and query requests.
// ----------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o is low; its one result
// appears for a single cycle with done_o high and cannot be held off, so the
// receiver must take it then. The table lives in one memory of REGIONS
// entries with a registered read; every request that passes its first checks
// walks it one entry at a time. Query runs the divider for each fitting RAM
// region. After a claim the merge pass reads every valid entry against every
// entry and starts over after each merge.
module memory_region_map_allocator_top #(
  parameter int REGIONS   = 32,
  parameter int ADDR_BITS = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  opcode_i,
  input  logic [47:0] range_base_i,
  input  logic [47:0] range_bound_i,
  input  logic [47:0] amount_i,
  input  logic [4:0]  align_log2_i,
  input  logic        from_top_i,
  input  logic        contiguous_i,
  input  logic [2:0]  region_class_i,
  input  logic [3:0]  region_use_i,
  input  logic [7:0]  tag_i,
  output logic        done_o,
  output logic [47:0] address_o,
  output logic [48:0] unit_count_o,
  output logic [2:0]  status_o
);

  localparam int AW  = ADDR_BITS;
  localparam int XW  = (AW > 48) ? AW : 48;
  localparam int UW  = (AW > 49) ? AW : 49;
  localparam int IW  = $clog2(REGIONS);
  localparam int UCW = $clog2(REGIONS + 1);
  localparam int DCW = $clog2(AW);

  typedef struct packed {
    logic [AW-1:0] rstart;
    logic [AW-1:0] rend;
    logic [2:0]    kind;
    logic [3:0]    purpose;
    logic [7:0]    label;
  } entry_t;

  mrm_pkg::state_e state_q, state_d;

  // request registers
  mrm_pkg::op_e  op_q, op_d;
  logic [AW-1:0] lo_q, lo_d, hi_q, hi_d, amask_q, amask_d;
  logic [47:0]   n_q, n_d;
  logic          top_q, top_d, contig_q, contig_d;
  logic [2:0]    cls_q, cls_d;
  logic [3:0]    use_q, use_d;
  logic [7:0]    tag_q, tag_d;
  logic          claim_q, claim_d;
  logic [AW-1:0] cb_q, cb_d, ce_q, ce_d;

  // table control
  logic [REGIONS-1:0] valid_q, valid_d;
  logic [UCW-1:0]     used_q, used_d;
  logic [IW-1:0]      idx_q, idx_d, jdx_q, jdx_d;

  // scan results
  logic          hit_q, hit_d;
  logic [1:0]    nfree_q, nfree_d;
  logic [IW-1:0] free1_q, free1_d, free2_q, free2_d;
  logic          rfound_q, rfound_d;
  logic [IW-1:0] ridx_q, ridx_d;
  entry_t        r_q, r_d;

  // per-entry clip pipeline
  logic          k_ok_q, k_ok_d;
  logic [AW-1:0] k_b_q, k_b_d, k_e_q, k_e_d, k_start_q, k_start_d;
  logic          fit_q, fit_d;
  logic [AW-1:0] w_q, w_d;
  logic          best_vld_q, best_vld_d;
  logic [AW-1:0] best_start_q, best_start_d, best_w_q, best_w_d;

  // divider and counters
  logic [48:0]    rem_q, rem_d;
  logic [AW-1:0]  dq_q, dq_d;
  logic [DCW-1:0] dcnt_q, dcnt_d;
  logic [48:0]    most_q, most_d, total_q, total_d;

  // results
  logic        done_q, done_d;
  logic [47:0] addr_q, addr_d;
  logic [48:0] cnt_q, cnt_d;
  logic [2:0]  status_q, status_d;

  // memory ports
  entry_t        region_mem [REGIONS];
  entry_t        rd_q;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;

  // shared conditions
  logic          mode_add, mode_claim, mode_alloc, mode_query;
  logic          ent_v, lo_in, hi_in, cb_in, scan_last, jdx_last;
  logic [AW-1:0] him1;
  logic          c_ok1;
  logic [AW-1:0] c_b, c_e;
  logic [AW:0]   al_sum;
  logic [AW-1:0] bal;
  logic          ok2;
  logic [XW-1:0] wt;
  logic          fit_top, fit_bot, take, best_nx, add_hit_nx;
  logic [AW-1:0] best_w_nx;
  logic [48:0]   dv_t;
  logic          dv_ge, div_last;
  logic [AW-1:0] quot;
  logic [UW-1:0] u_x;
  logic [48:0]   u_c;
  logic [49:0]   sum_x;
  logic [48:0]   most_nx, total_nx;
  logic          split_lo, split_hi;
  logic [1:0]    need;
  logic [IW-1:0] cur_idx, hi_idx;
  logic          claim_bad;
  logic          join_ok;
  mrm_pkg::state_e end_state, adv_state;

  assign mode_add   = (op_q == mrm_pkg::OP_ADD);
  assign mode_claim = claim_q;
  assign mode_alloc = (op_q == mrm_pkg::OP_ALLOC) && !claim_q;
  assign mode_query = (op_q == mrm_pkg::OP_QUERY);

  // entry hit tests
  assign ent_v     = valid_q[idx_q];
  assign him1      = hi_q - AW'(1);
  assign lo_in     = ent_v && (rd_q.rstart <= lo_q) && (lo_q < rd_q.rend);
  assign hi_in     = ent_v && (rd_q.rstart <= him1) && (him1 < rd_q.rend);
  assign cb_in     = ent_v && (rd_q.rstart <= cb_q) && (cb_q < rd_q.rend);
  assign scan_last = (idx_q == IW'(REGIONS - 1));
  assign jdx_last  = (jdx_q == IW'(REGIONS - 1));
  assign add_hit_nx = hit_q || lo_in || hi_in;

  // clip, first stage: available RAM intersected with the limits
  assign c_ok1 = ent_v && (rd_q.kind == mrm_pkg::CLASS_RAM) &&
                 (rd_q.purpose == mrm_pkg::USE_AVAIL);
  assign c_b   = (rd_q.rstart > lo_q) ? rd_q.rstart : lo_q;
  assign c_e   = (rd_q.rend < hi_q) ? rd_q.rend : hi_q;

  // clip, second stage: align the start up, drop on wrap or if empty
  assign al_sum = {1'b0, k_b_q} + {1'b0, amask_q};
  assign bal    = al_sum[AW-1:0] & ~amask_q;
  assign ok2    = k_ok_q && !al_sum[AW] && (bal < k_e_q);

  // block placement inside the clipped range
  assign wt      = (XW'(k_e_q) - XW'(n_q)) & ~XW'(amask_q);
  assign fit_top = k_ok_q && !(XW'(n_q) > XW'(k_e_q)) && (wt >= XW'(k_b_q));
  assign fit_bot = k_ok_q && !(XW'(n_q) > XW'(k_e_q - k_b_q));
  assign take    = fit_q && (!best_vld_q || (k_start_q > best_start_q));
  assign best_nx   = best_vld_q || take;
  assign best_w_nx = take ? w_q : best_w_q;

  // restoring divider step
  assign dv_t     = {rem_q[47:0], dq_q[AW-1]};
  assign dv_ge    = (dv_t >= {1'b0, n_q});
  assign quot     = {dq_q[AW-2:0], dv_ge};
  assign div_last = (dcnt_q == DCW'(AW - 1));

  // saturating accumulation of units
  assign u_x      = UW'(quot);
  assign u_c      = (u_x > UW'(mrm_pkg::CNT_MAX)) ? mrm_pkg::CNT_MAX : u_x[48:0];
  assign sum_x    = {1'b0, total_q} + {1'b0, u_c};
  assign most_nx  = (state_q == mrm_pkg::ST_DIV && div_last && u_c > most_q) ?
                    u_c : most_q;
  assign total_nx = (state_q == mrm_pkg::ST_DIV && div_last) ?
                    ((sum_x > {1'b0, mrm_pkg::CNT_MAX}) ? mrm_pkg::CNT_MAX : sum_x[48:0]) :
                    total_q;

  // claim split plan
  assign split_lo  = (cb_q > r_q.rstart);
  assign split_hi  = (ce_q < r_q.rend);
  assign need      = {1'b0, split_lo} + {1'b0, split_hi};
  assign cur_idx   = split_lo ? free1_q : ridx_q;
  assign hi_idx    = split_lo ? free2_q : free1_q;
  assign claim_bad = !rfound_q || (ce_q > r_q.rend) ||
                     (UCW'(need) > (UCW'(REGIONS) - used_q));

  // merge test: entry i held in r_q, entry j on the read port
  assign join_ok = valid_q[jdx_q] && (idx_q != jdx_q) && (r_q.rend == rd_q.rstart) &&
                   (r_q.kind == rd_q.kind) && (r_q.purpose == rd_q.purpose) &&
                   (r_q.label == rd_q.label) && (r_q.purpose != mrm_pkg::USE_DEV) &&
                   (r_q.purpose != mrm_pkg::USE_DEVPAGES);

  // where a finished scan goes
  always_comb begin
    if (mode_add) begin
      end_state = add_hit_nx ? mrm_pkg::ST_IDLE : mrm_pkg::ST_ADD_WR;
    end else if (mode_claim) begin
      end_state = mrm_pkg::ST_CLAIM_CHK;
    end else if (mode_alloc) begin
      end_state = best_nx ? mrm_pkg::ST_CLAIM_BEGIN : mrm_pkg::ST_IDLE;
    end else begin
      end_state = mrm_pkg::ST_IDLE;
    end
    adv_state = scan_last ? end_state : mrm_pkg::ST_SCAN_RD;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mrm_pkg::ST_IDLE: begin
        if (start_i) state_d = mrm_pkg::ST_DECODE;
      end
      mrm_pkg::ST_DECODE: begin
        unique case (op_q)
          mrm_pkg::OP_ADD: begin
            if (used_q >= UCW'(REGIONS) || lo_q >= hi_q ||
                cls_q == mrm_pkg::CLASS_UNUSED) begin
              state_d = mrm_pkg::ST_IDLE;
            end else begin
              state_d = mrm_pkg::ST_SCAN_RD;
            end
          end
          mrm_pkg::OP_CLAIM: state_d = mrm_pkg::ST_CLAIM_BEGIN;
          mrm_pkg::OP_ALLOC: state_d = mrm_pkg::ST_SCAN_RD;
          mrm_pkg::OP_QUERY: begin
            state_d = (n_q == '0) ? mrm_pkg::ST_IDLE : mrm_pkg::ST_SCAN_RD;
          end
        endcase
      end
      mrm_pkg::ST_CLAIM_BEGIN: begin
        state_d = (cb_q >= ce_q) ? mrm_pkg::ST_IDLE : mrm_pkg::ST_SCAN_RD;
      end
      mrm_pkg::ST_SCAN_RD: state_d = mrm_pkg::ST_SCAN_EV;
      mrm_pkg::ST_SCAN_EV: begin
        state_d = (mode_alloc || mode_query) ? mrm_pkg::ST_CLIP : adv_state;
      end
      mrm_pkg::ST_CLIP: state_d = mrm_pkg::ST_FIT;
      mrm_pkg::ST_FIT: begin
        if (mode_alloc) state_d = mrm_pkg::ST_PICK;
        else            state_d = k_ok_q ? mrm_pkg::ST_DIV : adv_state;
      end
      mrm_pkg::ST_PICK: state_d = adv_state;
      mrm_pkg::ST_DIV: begin
        if (div_last) state_d = adv_state;
      end
      mrm_pkg::ST_ADD_WR: state_d = mrm_pkg::ST_IDLE;
      mrm_pkg::ST_CLAIM_CHK: begin
        if (claim_bad)     state_d = mrm_pkg::ST_IDLE;
        else if (split_lo) state_d = mrm_pkg::ST_WR_LO;
        else if (split_hi) state_d = mrm_pkg::ST_WR_HI;
        else               state_d = mrm_pkg::ST_WR_CUR;
      end
      mrm_pkg::ST_WR_LO: state_d = split_hi ? mrm_pkg::ST_WR_HI : mrm_pkg::ST_WR_CUR;
      mrm_pkg::ST_WR_HI: state_d = mrm_pkg::ST_WR_CUR;
      mrm_pkg::ST_WR_CUR: state_d = mrm_pkg::ST_MG_RDI;
      mrm_pkg::ST_MG_RDI: state_d = mrm_pkg::ST_MG_LDI;
      mrm_pkg::ST_MG_LDI: begin
        if (valid_q[idx_q]) state_d = mrm_pkg::ST_MG_RDJ;
        else state_d = scan_last ? mrm_pkg::ST_IDLE : mrm_pkg::ST_MG_RDI;
      end
      mrm_pkg::ST_MG_RDJ: state_d = mrm_pkg::ST_MG_EVJ;
      mrm_pkg::ST_MG_EVJ: begin
        if (join_ok)       state_d = mrm_pkg::ST_MG_RDI;
        else if (!jdx_last) state_d = mrm_pkg::ST_MG_RDJ;
        else state_d = scan_last ? mrm_pkg::ST_IDLE : mrm_pkg::ST_MG_RDI;
      end
      default: state_d = mrm_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    logic          fin;
    logic [2:0]    fin_status;
    logic [AW-1:0] fin_addr;
    logic [48:0]   fin_cnt;
    logic          do_adv;
    logic          next_i;

    fin = 1'b0;
    fin_status = mrm_pkg::STS_OK;
    fin_addr = '0;
    fin_cnt = '0;
    do_adv = 1'b0;
    next_i = 1'b0;

    op_d = op_q;  lo_d = lo_q;  hi_d = hi_q;  n_d = n_q;  amask_d = amask_q;
    top_d = top_q;  contig_d = contig_q;  cls_d = cls_q;  use_d = use_q;
    tag_d = tag_q;  claim_d = claim_q;  cb_d = cb_q;  ce_d = ce_q;
    valid_d = valid_q;  used_d = used_q;  idx_d = idx_q;  jdx_d = jdx_q;
    hit_d = hit_q;  nfree_d = nfree_q;  free1_d = free1_q;  free2_d = free2_q;
    rfound_d = rfound_q;  ridx_d = ridx_q;  r_d = r_q;
    k_ok_d = k_ok_q;  k_b_d = k_b_q;  k_e_d = k_e_q;  k_start_d = k_start_q;
    fit_d = fit_q;  w_d = w_q;  best_vld_d = best_vld_q;
    best_start_d = best_start_q;  best_w_d = best_w_q;
    rem_d = rem_q;  dq_d = dq_q;  dcnt_d = dcnt_q;
    most_d = most_q;  total_d = total_q;
    addr_d = addr_q;  cnt_d = cnt_q;  status_d = status_q;

    rd_en = 1'b0;
    rd_addr = idx_q;
    wr_en = 1'b0;
    wr_addr = idx_q;
    wr_data = r_q;

    unique case (state_q)
      mrm_pkg::ST_IDLE: begin
        if (start_i) begin
          op_d     = mrm_pkg::op_e'(opcode_i);
          lo_d     = AW'(range_base_i);
          hi_d     = AW'(range_bound_i);
          n_d      = amount_i;
          amask_d  = AW'((32'd1 << align_log2_i) - 32'd1);
          top_d    = from_top_i;
          contig_d = contiguous_i;
          cls_d    = region_class_i;
          use_d    = region_use_i;
          tag_d    = tag_i;
          claim_d  = 1'b0;
        end
      end
      mrm_pkg::ST_DECODE: begin
        idx_d = '0;
        hit_d = 1'b0;
        nfree_d = '0;
        best_vld_d = 1'b0;
        most_d = '0;
        total_d = '0;
        unique case (op_q)
          mrm_pkg::OP_ADD: begin
            if (used_q >= UCW'(REGIONS)) begin
              fin = 1'b1;
              fin_status = mrm_pkg::STS_FULL;
            end else if (lo_q >= hi_q) begin
              fin = 1'b1;
              fin_status = mrm_pkg::STS_NOFIT;
            end else if (cls_q == mrm_pkg::CLASS_UNUSED) begin
              fin = 1'b1;
            end
          end
          mrm_pkg::OP_CLAIM: begin
            cb_d = lo_q;
            ce_d = hi_q;
          end
          mrm_pkg::OP_ALLOC: ;
          mrm_pkg::OP_QUERY: begin
            if (n_q == '0) begin
              fin = 1'b1;
              fin_status = mrm_pkg::STS_ZERO_UNIT;
            end
          end
        endcase
      end
      mrm_pkg::ST_CLAIM_BEGIN: begin
        if (cb_q == ce_q) begin
          fin = 1'b1;
        end else if (cb_q > ce_q) begin
          fin = 1'b1;
          fin_status = mrm_pkg::STS_OUTSIDE;
        end else begin
          claim_d = 1'b1;
          idx_d = '0;
          rfound_d = 1'b0;
          nfree_d = '0;
        end
      end
      mrm_pkg::ST_SCAN_RD: begin
        rd_en = 1'b1;
        rd_addr = idx_q;
      end
      mrm_pkg::ST_SCAN_EV: begin
        if (mode_alloc || mode_query) begin
          k_ok_d = c_ok1;
          k_b_d = c_b;
          k_e_d = c_e;
          k_start_d = rd_q.rstart;
        end else begin
          // first two free slots
          if (!ent_v) begin
            if (nfree_q == 2'd0) begin
              free1_d = idx_q;
              nfree_d = 2'd1;
            end else if (nfree_q == 2'd1) begin
              free2_d = idx_q;
              nfree_d = 2'd2;
            end
          end
          if (mode_add) hit_d = add_hit_nx;
          // first region holding the claim start
          if (mode_claim && cb_in && !rfound_q) begin
            rfound_d = 1'b1;
            ridx_d = idx_q;
            r_d = rd_q;
          end
          do_adv = 1'b1;
        end
      end
      mrm_pkg::ST_CLIP: begin
        k_b_d = bal;
        k_ok_d = ok2;
      end
      mrm_pkg::ST_FIT: begin
        if (mode_alloc) begin
          fit_d = top_q ? fit_top : fit_bot;
          w_d = top_q ? AW'(wt) : k_b_q;
        end else if (k_ok_q) begin
          rem_d = '0;
          dq_d = k_e_q - k_b_q;
          dcnt_d = '0;
        end else begin
          do_adv = 1'b1;
        end
      end
      mrm_pkg::ST_PICK: begin
        if (take) begin
          best_vld_d = 1'b1;
          best_start_d = k_start_q;
          best_w_d = w_q;
        end
        do_adv = 1'b1;
      end
      mrm_pkg::ST_DIV: begin
        rem_d = dv_ge ? (dv_t - {1'b0, n_q}) : dv_t;
        dq_d = quot;
        dcnt_d = dcnt_q + DCW'(1);
        if (div_last) begin
          most_d = most_nx;
          total_d = total_nx;
          do_adv = 1'b1;
        end
      end
      mrm_pkg::ST_ADD_WR: begin
        wr_en = 1'b1;
        wr_addr = free1_q;
        wr_data = '{rstart: lo_q, rend: hi_q, kind: cls_q, purpose: use_q, label: tag_q};
        valid_d[free1_q] = 1'b1;
        used_d = used_q + UCW'(1);
        fin = 1'b1;
      end
      mrm_pkg::ST_CLAIM_CHK: begin
        if (!rfound_q) begin
          fin = 1'b1;
          fin_status = mrm_pkg::STS_NOFIT;
        end else if (ce_q > r_q.rend) begin
          fin = 1'b1;
          fin_status = mrm_pkg::STS_OUTSIDE;
        end else if (claim_bad) begin
          fin = 1'b1;
          fin_status = mrm_pkg::STS_FULL;
        end
      end
      mrm_pkg::ST_WR_LO: begin
        // lower remainder keeps the original slot
        wr_en = 1'b1;
        wr_addr = ridx_q;
        wr_data = r_q;
        wr_data.rend = cb_q;
      end
      mrm_pkg::ST_WR_HI: begin
        // upper remainder into a free slot
        wr_en = 1'b1;
        wr_addr = hi_idx;
        wr_data = r_q;
        wr_data.rstart = ce_q;
        valid_d[hi_idx] = 1'b1;
      end
      mrm_pkg::ST_WR_CUR: begin
        // the claimed range with its new labels
        wr_en = 1'b1;
        wr_addr = cur_idx;
        wr_data = '{rstart: cb_q, rend: ce_q, kind: cls_q, purpose: use_q, label: tag_q};
        valid_d[cur_idx] = (cls_q != mrm_pkg::CLASS_UNUSED);
        used_d = used_q + UCW'(need) - UCW'(cls_q == mrm_pkg::CLASS_UNUSED);
        idx_d = '0;
      end
      mrm_pkg::ST_MG_RDI: begin
        rd_en = 1'b1;
        rd_addr = idx_q;
      end
      mrm_pkg::ST_MG_LDI: begin
        r_d = rd_q;
        jdx_d = '0;
        if (!valid_q[idx_q]) next_i = 1'b1;
      end
      mrm_pkg::ST_MG_RDJ: begin
        rd_en = 1'b1;
        rd_addr = jdx_q;
      end
      mrm_pkg::ST_MG_EVJ: begin
        if (join_ok) begin
          wr_en = 1'b1;
          wr_addr = idx_q;
          wr_data = r_q;
          wr_data.rend = rd_q.rend;
          valid_d[jdx_q] = 1'b0;
          used_d = used_q - UCW'(1);
          idx_d = '0;
        end else if (!jdx_last) begin
          jdx_d = jdx_q + IW'(1);
        end else begin
          next_i = 1'b1;
        end
      end
      default: ;
    endcase

    // step the table scan
    if (do_adv) begin
      if (!scan_last) begin
        idx_d = idx_q + IW'(1);
      end else if (mode_add) begin
        if (add_hit_nx) begin
          fin = 1'b1;
          fin_status = mrm_pkg::STS_OVERLAP;
        end
      end else if (mode_alloc) begin
        if (best_nx) begin
          cb_d = best_w_nx;
          ce_d = AW'(XW'(best_w_nx) + XW'(n_q));
          cls_d = mrm_pkg::CLASS_RAM;
        end else begin
          fin = 1'b1;
          fin_status = mrm_pkg::STS_NOFIT;
        end
      end else if (mode_query) begin
        fin = 1'b1;
        fin_cnt = contig_q ? most_nx : total_nx;
      end
    end

    // step the merge outer loop
    if (next_i) begin
      if (scan_last) begin
        fin = 1'b1;
        fin_addr = cb_q;
      end else begin
        idx_d = idx_q + IW'(1);
      end
    end

    done_d = fin;
    if (fin) begin
      addr_d = 48'(fin_addr);
      cnt_d = fin_cnt;
      status_d = fin_status;
    end
  end

  // table memory
  always_ff @(posedge clk_i) begin
    if (rd_en) rd_q <= region_mem[rd_addr];
    if (wr_en) region_mem[wr_addr] <= wr_data;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mrm_pkg::ST_IDLE;
      valid_q <= '0;
      used_q  <= '0;
      claim_q <= 1'b0;
      done_q  <= 1'b0;
      idx_q   <= '0;
      jdx_q   <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      used_q  <= used_d;
      claim_q <= claim_d;
      done_q  <= done_d;
      idx_q   <= idx_d;
      jdx_q   <= jdx_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q <= op_d;  lo_q <= lo_d;  hi_q <= hi_d;  n_q <= n_d;  amask_q <= amask_d;
    top_q <= top_d;  contig_q <= contig_d;  cls_q <= cls_d;  use_q <= use_d;
    tag_q <= tag_d;  cb_q <= cb_d;  ce_q <= ce_d;
    hit_q <= hit_d;  nfree_q <= nfree_d;  free1_q <= free1_d;  free2_q <= free2_d;
    rfound_q <= rfound_d;  ridx_q <= ridx_d;  r_q <= r_d;
    k_ok_q <= k_ok_d;  k_b_q <= k_b_d;  k_e_q <= k_e_d;  k_start_q <= k_start_d;
    fit_q <= fit_d;  w_q <= w_d;  best_vld_q <= best_vld_d;
    best_start_q <= best_start_d;  best_w_q <= best_w_d;
    rem_q <= rem_d;  dq_q <= dq_d;  dcnt_q <= dcnt_d;
    most_q <= most_d;  total_q <= total_d;
    addr_q <= addr_d;  cnt_q <= cnt_d;  status_q <= status_d;
  end

  assign busy_o       = (state_q != mrm_pkg::ST_IDLE);
  assign done_o       = done_q;
  assign address_o    = addr_q;
  assign unit_count_o = cnt_q;
  assign status_o     = status_q;

endmodule
